@@ rtl/blr_pkg.sv @@
// Bresenham line rasterizer: shared package.
// Holds field widths, request/result structs and codes. No dependencies.
`default_nettype none

package blr_pkg;

    // Fixed field widths
    localparam int COORD_BITS = 16;
    localparam int ADDR_BITS  = 24;
    localparam int DIM_BITS   = 13;
    localparam int COLOR_BITS = 32;
    // Error term holds dx - dy plus one step of either, doubled for e2
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int E2_BITS    = COORD_BITS + 3;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = (ADDR_BITS > DIM_BITS) ? ADDR_BITS : DIM_BITS;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_CANVAS_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_CANVAS_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_ROW_STRIDE    = 2'd2;
    localparam t_cfg_idx CFG_BASE_ADDRESS  = 2'd3;

    // Request kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [COORD_BITS-1:0] t_span;
    typedef logic signed [ERR_BITS-1:0]   t_err;
    typedef logic        [ADDR_BITS-1:0]  t_addr;
    typedef logic        [DIM_BITS-1:0]   t_dim;
    typedef logic        [COLOR_BITS-1:0] t_color;

    // Input request
    typedef struct packed {
        logic   kind;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
        t_color line_color;
    } t_req;

    // Output result
    typedef struct packed {
        logic   valid_res;
        t_coord pixel_x;
        t_coord pixel_y;
        t_addr  pixel_address;
        t_color pixel_color;
        logic   write_enable;
        logic   last;
    } t_res;

    // Pixel handed from the walker to the address stage
    typedef struct packed {
        logic   valid;
        t_coord x;
        t_coord y;
        t_color color;
        logic   last;
    } t_pix;

    // Canvas configuration
    typedef struct packed {
        t_dim  width;
        t_dim  height;
        t_dim  stride;
        t_addr base;
    } t_cfg;

    // Line walker state
    typedef struct packed {
        t_coord cur_x;
        t_coord cur_y;
        t_coord target_x;
        t_coord target_y;
        t_span  abs_dx;
        t_span  abs_dy;
        logic   x_dir_neg;
        logic   y_dir_neg;
        t_err   error_term;
        t_color held_color;
        logic   busy;
    } t_walk;

endpackage

`default_nettype wire

@@ rtl/blr_walker.sv @@
// Bresenham line walker: line setup and one error-term step per request.
// Holds the line state and the pixel register. Depends on blr_pkg.
`default_nettype none

module blr_walker import blr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_pix      o_pix
);

    t_walk r_walk, n_walk;
    t_pix  r_pix,  n_pix;
    logic  r_valid;
    logic  w_accept;

    // Setup terms
    logic signed [COORD_BITS:0] w_dx, w_dy;
    t_span                      w_abs_dx, w_abs_dy;
    // Step terms
    logic signed [E2_BITS-1:0]  w_e2;
    logic                       w_move_x, w_move_y;
    t_coord                     w_nx, w_ny;
    t_err                       w_nerr;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_pix    = r_pix;

    // Start setup: deltas, magnitudes, directions
    always_comb begin
        w_dx     = {i_req.end_x[COORD_BITS-1], i_req.end_x}
                 - {i_req.start_x[COORD_BITS-1], i_req.start_x};
        w_dy     = {i_req.end_y[COORD_BITS-1], i_req.end_y}
                 - {i_req.start_y[COORD_BITS-1], i_req.start_y};
        w_abs_dx = w_dx[COORD_BITS] ? COORD_BITS'(-w_dx) : w_dx[COORD_BITS-1:0];
        w_abs_dy = w_dy[COORD_BITS] ? COORD_BITS'(-w_dy) : w_dy[COORD_BITS-1:0];
    end

    // One step: x moves when e2 > -dy, y moves when e2 < dx
    always_comb begin
        w_e2     = {r_walk.error_term, 1'b0};
        w_move_x = w_e2 > -$signed({3'b000, r_walk.abs_dy});
        w_move_y = w_e2 <  $signed({3'b000, r_walk.abs_dx});
        w_nerr   = r_walk.error_term
                 - (w_move_x ? $signed({2'b00, r_walk.abs_dy}) : t_err'(0))
                 + (w_move_y ? $signed({2'b00, r_walk.abs_dx}) : t_err'(0));
        w_nx     = r_walk.cur_x;
        w_ny     = r_walk.cur_y;
        if (w_move_x) begin
            w_nx = r_walk.x_dir_neg ? r_walk.cur_x - t_coord'(1)
                                    : r_walk.cur_x + t_coord'(1);
        end
        if (w_move_y) begin
            w_ny = r_walk.y_dir_neg ? r_walk.cur_y - t_coord'(1)
                                    : r_walk.cur_y + t_coord'(1);
        end
    end

    // Next state and pixel
    always_comb begin
        n_walk = r_walk;
        n_pix  = '0;
        if (i_req.kind == KIND_START) begin
            n_walk.cur_x      = i_req.start_x;
            n_walk.cur_y      = i_req.start_y;
            n_walk.target_x   = i_req.end_x;
            n_walk.target_y   = i_req.end_y;
            n_walk.abs_dx     = w_abs_dx;
            n_walk.abs_dy     = w_abs_dy;
            n_walk.x_dir_neg  = w_dx[COORD_BITS] || (w_dx == '0);
            n_walk.y_dir_neg  = w_dy[COORD_BITS] || (w_dy == '0);
            n_walk.error_term = $signed({2'b00, w_abs_dx}) - $signed({2'b00, w_abs_dy});
            n_walk.held_color = i_req.line_color;
        end else if (r_walk.busy) begin
            n_walk.cur_x      = w_nx;
            n_walk.cur_y      = w_ny;
            n_walk.error_term = w_nerr;
        end
        // End point reached closes the line
        if (i_req.kind == KIND_START || r_walk.busy) begin
            n_pix.valid = 1'b1;
            n_pix.x     = n_walk.cur_x;
            n_pix.y     = n_walk.cur_y;
            n_pix.color = n_walk.held_color;
            n_pix.last  = (n_walk.cur_x == n_walk.target_x)
                       && (n_walk.cur_y == n_walk.target_y);
            n_walk.busy = !n_pix.last;
        end
    end

    // State and pixel register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_walk <= n_walk;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix <= n_pix;
        end
    end

    // A step with no line in progress yields an empty pixel
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.kind == KIND_STEP && !r_walk.busy)
        |=> (r_valid && !r_pix.valid))
        else $error("step without active line produced a pixel");

    // A start always produces a pixel
    a_start_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.kind == KIND_START) |=> (r_valid && r_pix.valid))
        else $error("start request produced no pixel");

    // The line stays active exactly when the held pixel is not its end point
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_pix.valid) |-> (r_pix.last != r_walk.busy))
        else $error("last flag and active-line state disagree");

endmodule

`default_nettype wire

@@ rtl/blr_addr.sv @@
// Address and clip stage: frame-store address and canvas write enable.
// Holds the result register. Depends on blr_pkg.
`default_nettype none

module blr_addr import blr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_pix i_pix,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_res      o_res
);

    t_res  r_res, n_res;
    logic  r_valid;
    t_addr w_y_ext, w_x_ext, w_stride;
    t_addr w_prod;
    logic  w_x_in, w_y_in;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // base + y*stride + x, wrapping at the address width
    always_comb begin
        w_y_ext  = {{(ADDR_BITS-COORD_BITS){i_pix.y[COORD_BITS-1]}}, i_pix.y};
        w_x_ext  = {{(ADDR_BITS-COORD_BITS){i_pix.x[COORD_BITS-1]}}, i_pix.x};
        w_stride = {{(ADDR_BITS-DIM_BITS){1'b0}}, i_cfg.stride};
        w_prod   = w_y_ext * w_stride;
    end

    // Canvas clip: non-negative and below the dimension
    always_comb begin
        w_x_in = !i_pix.x[COORD_BITS-1]
              && (i_pix.x[COORD_BITS-1:0] < {{(COORD_BITS-DIM_BITS){1'b0}}, i_cfg.width});
        w_y_in = !i_pix.y[COORD_BITS-1]
              && (i_pix.y[COORD_BITS-1:0] < {{(COORD_BITS-DIM_BITS){1'b0}}, i_cfg.height});
    end

    // Empty pixels give an all-zero result
    always_comb begin
        n_res = '0;
        if (i_pix.valid) begin
            n_res.valid_res     = 1'b1;
            n_res.pixel_x       = i_pix.x;
            n_res.pixel_y       = i_pix.y;
            n_res.pixel_address = i_cfg.base + w_prod + w_x_ext;
            n_res.pixel_color   = i_pix.color;
            n_res.write_enable  = w_x_in && w_y_in;
            n_res.last          = i_pix.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

    // Empty results carry nothing
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_res.valid_res) |-> (r_res == '0))
        else $error("empty result carries nonzero fields");

    // Write enable only on a real pixel with nonzero canvas
    a_we_canvas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.write_enable)
        |-> (r_res.valid_res && i_cfg.width != '0 && i_cfg.height != '0))
        else $error("write enable outside a nonempty canvas");

endmodule

`default_nettype wire

@@ rtl/bresenham_line_rasterizer.sv @@
// Bresenham line rasterizer top level: configuration registers and the
// two-stage walker / address pipeline. Depends on blr_pkg, blr_walker, blr_addr.
`default_nettype none

// One request in, one result out, one request per clock sustained while the
// result channel does not stall. A start request loads the endpoints and color
// and returns the first pixel; each step request returns the next pixel of the
// line, or an empty result (valid_res=0, all other fields zero) when no line is
// active. Each result passes the walker register, which closes the Bresenham
// error-term step, then the result register after the address multiply-add and
// canvas clip. A start during a line abandons it. Write the configuration
// registers only while no request is in flight.
module bresenham_line_rasterizer import blr_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Configuration write port
    input  wire logic                     i_cfg_we,
    input  wire t_cfg_idx                 i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // Request channel
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire t_req                     i_in_req,
    // Result channel
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output t_res                          o_out_res
);

    t_cfg r_cfg;
    logic w_pix_valid, w_pix_ready;
    t_pix w_pix;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CANVAS_WIDTH:  r_cfg.width  <= i_cfg_data[DIM_BITS-1:0];
                CFG_CANVAS_HEIGHT: r_cfg.height <= i_cfg_data[DIM_BITS-1:0];
                CFG_ROW_STRIDE:    r_cfg.stride <= i_cfg_data[DIM_BITS-1:0];
                CFG_BASE_ADDRESS:  r_cfg.base   <= i_cfg_data[ADDR_BITS-1:0];
                default: ;
            endcase
        end
    end

    blr_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_req   (i_in_req),
        .o_valid (w_pix_valid),
        .i_ready (w_pix_ready),
        .o_pix   (w_pix)
    );

    blr_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_pix_valid),
        .o_ready (w_pix_ready),
        .i_pix   (w_pix),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (o_out_res)
    );

endmodule

`default_nettype wire

@@ test/tb_bresenham_line_rasterizer.sv @@
// Self-checking testbench for the Bresenham line rasterizer: directed table, then random lines.
// Predicts each pixel from its own copy of the line walker and the canvas registers.
// Depends on blr_pkg and bresenham_line_rasterizer.
module tb_bresenham_line_rasterizer;
    timeunit 1ns;
    timeprecision 1ps;
    import blr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CAP     = 20000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 235;
    localparam int unsigned ADDR_TOP = 32'h00FF_FFFF;
    localparam t_res NO_PIXEL    = '0;

    // DUT ports
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_we    = 1'b0;
    t_cfg_idx                 i_cfg_index = CFG_CANVAS_WIDTH;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_ready;
    t_req                     i_in_req    = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    t_res                     o_out_res;

    bresenham_line_rasterizer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

    // Directed stimulus row; want is used only when typed is set
    typedef struct {
        t_req req;
        bit   typed;
        t_res want;
    } t_stim_row;

    t_stim_row   stim_table[$];
    t_res        pending_pixels[$];
    int unsigned cycle_count = 0;
    int          fail_count  = 0;
    int          items_sent  = 0;
    bit          in_gap_en   = 1'b1;
    bit          out_stall_en = 1'b1;
    bit          ready_level = 1'b1;
    int          ready_hold  = 0;
    t_res        want_px;

    // Predicted canvas registers
    t_dim  cv_width  = '0;
    t_dim  cv_height = '0;
    t_dim  cv_stride = '0;
    t_addr cv_base   = '0;

    // Predicted line walker
    t_coord ln_x = '0, ln_y = '0, ln_tx = '0, ln_ty = '0;
    t_span  ln_adx = '0, ln_ady = '0;
    logic   ln_xneg = 1'b0, ln_yneg = 1'b0;
    t_err   ln_err = '0;
    t_color ln_color = '0;
    logic   ln_active = 1'b0;

    // Clock and run limit
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result-side backpressure: mostly short stalls, a few long ones
    always @(posedge i_clk) begin
        if (ready_hold == 0) begin
            if (!out_stall_en || $urandom_range(0, 99) < 65) begin
                ready_level = 1'b1;
                ready_hold  = $urandom_range(1, 8);
            end else begin
                ready_level = 1'b0;
                ready_hold  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
            end
        end else begin
            ready_hold--;
        end
        i_out_ready <= ready_level;
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel result with none expected: %p", o_out_res);
                fail_count++;
            end else begin
                want_px = pending_pixels.pop_front();
                check_pixel(o_out_res, want_px);
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            fail_count++;
        end
    endtask

    task automatic check_pixel(t_res got, t_res want);
        check_field("valid_res", 32'(want.valid_res), 32'(got.valid_res));
        check_field("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
        check_field("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
        check_field("pixel_address", 32'(want.pixel_address), 32'(got.pixel_address));
        check_field("pixel_color", want.pixel_color, got.pixel_color);
        check_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
        check_field("last", 32'(want.last), 32'(got.last));
    endtask

    // Pixel at the walker's current position, clipped against the canvas
    function automatic t_res current_pixel(logic at_end);
        t_res   p;
        longint addr;
        int     x;
        int     y;
        x    = int'(ln_x);
        y    = int'(ln_y);
        addr = longint'(cv_base) + longint'(y) * longint'(cv_stride) + longint'(x);
        p.valid_res     = 1'b1;
        p.pixel_x       = ln_x;
        p.pixel_y       = ln_y;
        p.pixel_address = t_addr'(addr);
        p.pixel_color   = ln_color;
        p.write_enable  = (x >= 0) && (x < int'(cv_width)) &&
                          (y >= 0) && (y < int'(cv_height));
        p.last          = at_end;
        return p;
    endfunction

    // Advance the predicted walker by one request and return its pixel
    function automatic t_res trace_line_pixel(t_req r);
        int   x0, y0, x1, y1;
        int   adx, ady, err, e2, x, y;
        logic at_end;
        if (r.kind == KIND_START) begin
            x0 = int'(r.start_x);
            y0 = int'(r.start_y);
            x1 = int'(r.end_x);
            y1 = int'(r.end_y);
            adx = (x1 > x0) ? x1 - x0 : x0 - x1;
            ady = (y1 > y0) ? y1 - y0 : y0 - y1;
            ln_x     = r.start_x;
            ln_y     = r.start_y;
            ln_tx    = r.end_x;
            ln_ty    = r.end_y;
            ln_adx   = t_span'(adx);
            ln_ady   = t_span'(ady);
            ln_xneg  = !(x0 < x1);
            ln_yneg  = !(y0 < y1);
            ln_err   = t_err'(adx - ady);
            ln_color = r.line_color;
        end else begin
            if (!ln_active)
                return NO_PIXEL;
            adx = int'(ln_adx);
            ady = int'(ln_ady);
            err = int'(ln_err);
            x   = int'(ln_x);
            y   = int'(ln_y);
            e2  = 2 * err;
            // x moves when e2 > -dy, y moves when e2 < dx
            if (e2 > -ady) begin
                err -= ady;
                x   += ln_xneg ? -1 : 1;
            end
            if (e2 < adx) begin
                err += adx;
                y   += ln_yneg ? -1 : 1;
            end
            ln_err = t_err'(err);
            ln_x   = t_coord'(x);
            ln_y   = t_coord'(y);
        end
        at_end    = (ln_x == ln_tx) && (ln_y == ln_ty);
        ln_active = !at_end;
        return current_pixel(at_end);
    endfunction

    function automatic t_req make_req(logic kind, int sx, int sy, int ex, int ey,
                                      logic [31:0] color);
        t_req r;
        r.kind       = kind;
        r.start_x    = t_coord'(sx);
        r.start_y    = t_coord'(sy);
        r.end_x      = t_coord'(ex);
        r.end_y      = t_coord'(ey);
        r.line_color = color;
        return r;
    endfunction

    function automatic t_res pixel_at(int x, int y, t_addr addr, t_color color,
                                      logic we, logic at_end);
        t_res p;
        p.valid_res     = 1'b1;
        p.pixel_x       = t_coord'(x);
        p.pixel_y       = t_coord'(y);
        p.pixel_address = addr;
        p.pixel_color   = color;
        p.write_enable  = we;
        p.last          = at_end;
        return p;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Mostly around the canvas and its edges, sometimes anywhere
    function automatic int pick_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return int'($urandom_range(0, 316)) - 16;
            6, 7:             return int'($urandom_range(4080, 4111));
            8:                return int'($urandom_range(8180, 8200));
            default:          return any_coord();
        endcase
    endfunction

    function automatic int clamp_coord(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int abs_int(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (!in_gap_en)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Drive one request, wait for acceptance, queue its expected pixel
    task automatic send_req(t_req r, bit typed, t_res want);
        int   gap;
        t_res pred;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (!o_in_ready);
        pred = trace_line_pixel(r);
        pending_pixels.push_back(typed ? want : pred);
        items_sent++;
    endtask

    // Step request with junk in the unused fields
    task automatic send_step();
        send_req(make_req(KIND_STEP, any_coord(), any_coord(), any_coord(), any_coord(),
                          $urandom()), 1'b0, NO_PIXEL);
    endtask

    // Stop sending and let every expected pixel come back
    task automatic wait_results_done();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0 && waited < DRAIN_CAP) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_CANVAS_WIDTH:  cv_width  = data[DIM_BITS-1:0];
            CFG_CANVAS_HEIGHT: cv_height = data[DIM_BITS-1:0];
            CFG_ROW_STRIDE:    cv_stride = data[DIM_BITS-1:0];
            CFG_BASE_ADDRESS:  cv_base   = data[ADDR_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_canvas(int unsigned w, int unsigned h, int unsigned s,
                              int unsigned b);
        write_reg(CFG_CANVAS_WIDTH, CFG_DATA_BITS'(w));
        write_reg(CFG_CANVAS_HEIGHT, CFG_DATA_BITS'(h));
        write_reg(CFG_ROW_STRIDE, CFG_DATA_BITS'(s));
        write_reg(CFG_BASE_ADDRESS, CFG_DATA_BITS'(b));
        i_cfg_we <= 1'b0;
    endtask

    // A whole line: start, then steps to the end (sometimes past it, sometimes abandoned)
    task automatic send_line();
        int sx, sy, ex, ey, reach, span, n_steps;
        sx = pick_coord();
        sy = pick_coord();
        if ($urandom_range(0, 19) == 0) begin
            ex = any_coord();
            ey = any_coord();
        end else begin
            reach = ($urandom_range(0, 19) == 0) ? 200 : 12;
            ex = clamp_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
            ey = clamp_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
        end
        span = abs_int(ex - sx);
        if (abs_int(ey - sy) > span)
            span = abs_int(ey - sy);
        if (span > 300)
            n_steps = $urandom_range(0, 20);
        else if ($urandom_range(0, 6) == 0)
            n_steps = $urandom_range(0, span);
        else
            n_steps = span + int'($urandom_range(0, 2));
        send_req(make_req(KIND_START, sx, sy, ex, ey, $urandom()), 1'b0, NO_PIXEL);
        repeat (n_steps) send_step();
    endtask

    // Stray steps and starts with fully random fields
    task automatic send_noise();
        if ($urandom_range(0, 1) == 0) begin
            send_step();
        end else begin
            send_req(make_req(KIND_START, any_coord(), any_coord(), any_coord(), any_coord(),
                              $urandom()), 1'b0, NO_PIXEL);
            repeat ($urandom_range(0, 3)) send_step();
        end
    endtask

    task automatic run_phase(int count);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop) begin
            in_gap_en    = ($urandom_range(0, 99) < 85);
            out_stall_en = ($urandom_range(0, 99) < 85);
            if ($urandom_range(0, 99) < 85)
                send_line();
            else
                send_noise();
            // occasionally hold off until the pipeline is empty
            if ($urandom_range(0, 29) == 0)
                wait_results_done();
        end
    endtask

    // Directed rows, run with the canvas registers at their reset value (all zero)
    task automatic build_stim_table();
        t_stim_row row;
        t_req      reqs[25];
        bit        typed[25];
        t_res      wants[25];
        foreach (typed[i]) begin
            typed[i] = 1'b0;
            wants[i] = NO_PIXEL;
        end
        // step with no line after reset
        reqs[0]  = make_req(KIND_STEP, 0, 0, 0, 0, 32'h0);
        typed[0] = 1'b1;
        // degenerate line: one pixel, last set, no line left active
        reqs[1]  = make_req(KIND_START, 0, 0, 0, 0, 32'hFFFF_FFFF);
        typed[1] = 1'b1;
        wants[1] = pixel_at(0, 0, 24'h0, 32'hFFFF_FFFF, 1'b0, 1'b1);
        reqs[2]  = make_req(KIND_STEP, 0, 0, 0, 0, 32'h0);
        typed[2] = 1'b1;
        // full-range diagonal, corner to corner
        reqs[3]  = make_req(KIND_START, -32768, -32768, 32767, 32767, 32'h0);
        typed[3] = 1'b1;
        wants[3] = pixel_at(-32768, -32768, 24'hFF_8000, 32'h0, 1'b0, 1'b0);
        reqs[4]  = make_req(KIND_STEP, 0, 0, 0, 0, 32'h0);
        reqs[5]  = make_req(KIND_STEP, 0, 0, 0, 0, 32'h0);
        // start while busy, opposite corners
        reqs[6]  = make_req(KIND_START, 32767, -32768, -32768, 32767, 32'h1234_5678);
        typed[6] = 1'b1;
        wants[6] = pixel_at(32767, -32768, 24'h00_7FFF, 32'h1234_5678, 1'b0, 1'b0);
        reqs[7]  = make_req(KIND_STEP, 0, 0, 0, 0, 32'h0);
        reqs[8]  = make_req(KIND_STEP, 0, 0, 0, 0, 32'h0);
        // short vertical line going down from the top extreme, then a step past its end
        reqs[9]  = make_req(KIND_START, 32767, 32767, 32767, 32765, 32'hA5A5_A5A5);
        typed[9] = 1'b1;
        wants[9] = pixel_at(32767, 32767, 24'h00_7FFF, 32'hA5A5_A5A5, 1'b0, 1'b0);
        reqs[10] = make_req(KIND_STEP, 0, 0, 0, 0, 32'h0);
        reqs[11] = make_req(KIND_STEP, 0, 0, 0, 0, 32'h0);
        reqs[12] = make_req(KIND_STEP, 0, 0, 0, 0, 32'h0);
        typed[12] = 1'b1;
        // horizontal line, abandoned by a steep one
        reqs[13] = make_req(KIND_START, -5, 3, 2, 3, 32'h00FF_00FF);
        reqs[14] = make_req(KIND_STEP, 0, 0, 0, 0, 32'h0);
        reqs[15] = make_req(KIND_STEP, 0, 0, 0, 0, 32'h0);
        reqs[16] = make_req(KIND_START, 10, 20, 7, 25, 32'h7F80_01FE);
        for (int i = 17; i < 22; i++)
            reqs[i] = make_req(KIND_STEP, 0, 0, 0, 0, 32'h0);
        reqs[22] = make_req(KIND_STEP, 0, 0, 0, 0, 32'h0);
        typed[22] = 1'b1;
        // degenerate line at -1: address wraps to all ones
        reqs[23] = make_req(KIND_START, -1, -1, -1, -1, 32'h8000_0000);
        typed[23] = 1'b1;
        wants[23] = pixel_at(-1, -1, 24'hFF_FFFF, 32'h8000_0000, 1'b0, 1'b1);
        // step with every unused field busy: still an empty result
        reqs[24] = make_req(KIND_STEP, -32768, 32767, -1, 21845, 32'hC3C3_5A5A);
        typed[24] = 1'b1;
        foreach (reqs[i]) begin
            row.req   = reqs[i];
            row.typed = typed[i];
            row.want  = wants[i];
            stim_table.push_back(row);
        end
    endtask

    // Main sequence
    initial begin
        build_stim_table();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[i])
            send_req(stim_table[i].req, stim_table[i].typed, stim_table[i].want);
        wait_results_done();

        // 4096 by 4096 canvas, base at the top of the address space
        set_canvas(4096, 4096, 4096, ADDR_TOP);
        run_phase(PHASE_ITEMS);
        wait_results_done();
        set_canvas(320, 240, 320, $urandom_range(0, ADDR_TOP));
        run_phase(PHASE_ITEMS);
        wait_results_done();
        // empty canvas: nothing gets written
        set_canvas(0, 4096, 4096, $urandom_range(0, ADDR_TOP));
        run_phase(PHASE_ITEMS);
        wait_results_done();
        // raw 24-bit writes, only the low bits of the dimension registers count
        set_canvas($urandom_range(0, ADDR_TOP), $urandom_range(0, ADDR_TOP),
                   $urandom_range(0, ADDR_TOP), $urandom_range(0, ADDR_TOP));
        run_phase(PHASE_ITEMS);
        wait_results_done();
        set_canvas(1, 1, 1, 0);
        run_phase(PHASE_ITEMS);
        wait_results_done();
        set_canvas(4096, 0, 0, $urandom_range(0, ADDR_TOP));
        run_phase(PHASE_ITEMS);
        wait_results_done();

        if (pending_pixels.size() != 0) begin
            $error("%0d expected pixels never arrived", pending_pixels.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ bresenham_line_rasterizer.f @@
rtl/blr_pkg.sv
rtl/blr_walker.sv
rtl/blr_addr.sv
rtl/bresenham_line_rasterizer.sv
test/tb_bresenham_line_rasterizer.sv
